/* rtl/core/hgrl_pkg.sv */
// Package for the HTTP GET request line parser.
// Holds capacities, counter widths, result codes, the result item type and the prefix table.
// No dependencies.
package hgrl_pkg;

    // Length limits; a count at or above its limit is an error.
    localparam int PATH_CAPACITY  = 64;
    localparam int QUERY_CAPACITY = 128;

    // Saturating counters must hold the capacity itself.
    localparam int PATH_CNT_W  = $clog2(PATH_CAPACITY + 1);
    localparam int QUERY_CNT_W = $clog2(QUERY_CAPACITY + 1);

    // Fixed field widths of a result item.
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;
    localparam int PLEN_W  = 6;
    localparam int QLEN_W  = 7;

    // Kind of a result item.
    localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PATH    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_VERDICT = 2'd3;

    // Verdict codes.
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_METHOD = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_PATH  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_QUERY = 2'd3;

    // Characters that matter to the parser.
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_QMARK = 8'h3F;

    // One result item.
    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic [KIND_W-1:0] byte_kind;
        logic [STAT_W-1:0] status;
        logic [PLEN_W-1:0] path_length;
        logic [QLEN_W-1:0] query_length;
    } hgrl_result_t;

    // Method prefix "GET ", indexed by match position.
    function automatic logic [BYTE_W-1:0] prefix_char(input logic [1:0] pos);
        logic [BYTE_W-1:0] c;
        unique case (pos)
            2'd0:    c = 8'h47;
            2'd1:    c = 8'h45;
            2'd2:    c = 8'h54;
            default: c = CHAR_SPACE;
        endcase
        return c;
    endfunction

    // Bytes that close the request target.
    function automatic logic ends_target(input logic [BYTE_W-1:0] b);
        return (b == CHAR_SPACE) || (b == CHAR_CR) || (b == CHAR_LF) || (b == CHAR_NUL);
    endfunction

endpackage

/* rtl/core/hgrl_in_if.sv */
// Input channel of the request line parser: one byte or an end-of-line mark per item.
// Depends on hgrl_pkg for the byte width.
interface hgrl_in_if;
    logic                       valid;
    logic                       ready;
    logic [hgrl_pkg::BYTE_W-1:0] char_byte;
    logic                       line_end;

    modport source (output valid, output char_byte, output line_end, input ready);
    modport sink   (input valid, input char_byte, input line_end, output ready);
endinterface

/* rtl/core/hgrl_out_if.sv */
// Output channel of the request line parser: one tagged byte or a verdict per item.
// Depends on hgrl_pkg for the field widths.
interface hgrl_out_if;
    logic                        valid;
    logic                        ready;
    logic [hgrl_pkg::BYTE_W-1:0] byte_out;
    logic [hgrl_pkg::KIND_W-1:0] byte_kind;
    logic [hgrl_pkg::STAT_W-1:0] status;
    logic [hgrl_pkg::PLEN_W-1:0] path_length;
    logic [hgrl_pkg::QLEN_W-1:0] query_length;

    modport source (output valid, output byte_out, output byte_kind, output status,
                    output path_length, output query_length, input ready);
    modport sink   (input valid, input byte_out, input byte_kind, input status,
                    input path_length, input query_length, output ready);
endinterface

/* rtl/core/hgrl_parse.sv */
// Parser state machine: phase, prefix match, saturating path and query counters.
// Produces the result item for the current input combinationally. Depends on hgrl_pkg.
module hgrl_parse
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [hgrl_pkg::BYTE_W-1:0]   char_byte,
    input  logic                          line_end,
    output hgrl_pkg::hgrl_result_t        result
);

    typedef enum logic [2:0] {
        PH_PREFIX   = 3'd0,
        PH_PATH     = 3'd1,
        PH_QUERY    = 3'd2,
        PH_DONE_NOQ = 3'd3,
        PH_DONE_Q   = 3'd4
    } phase_t;

    localparam int PC_W = hgrl_pkg::PATH_CNT_W;
    localparam int QC_W = hgrl_pkg::QUERY_CNT_W;
    localparam logic [PC_W-1:0] PATH_CAP  = PC_W'(hgrl_pkg::PATH_CAPACITY);
    localparam logic [QC_W-1:0] QUERY_CAP = QC_W'(hgrl_pkg::QUERY_CAPACITY);

    phase_t          phase_reg,  phase_next;
    logic [1:0]      prefix_pos_reg, prefix_pos_next;
    logic            method_failed_reg, method_failed_next;
    logic [PC_W-1:0] path_count_reg, path_count_next;
    logic [QC_W-1:0] query_count_reg, query_count_next;

    // Counts widened so the fixed-width length fields can be cut from them.
    logic [PC_W+hgrl_pkg::PLEN_W-1:0] path_wide;
    logic [QC_W+hgrl_pkg::QLEN_W-1:0] query_wide;

    assign path_wide  = {{hgrl_pkg::PLEN_W{1'b0}}, path_count_reg};
    assign query_wide = {{hgrl_pkg::QLEN_W{1'b0}}, query_count_reg};

    // Next state and result for one item
    always_comb
    begin
        phase_next         = phase_reg;
        prefix_pos_next    = prefix_pos_reg;
        method_failed_next = method_failed_reg;
        path_count_next    = path_count_reg;
        query_count_next   = query_count_reg;

        result.byte_out     = '0;
        result.byte_kind    = hgrl_pkg::KIND_IGNORED;
        result.status       = hgrl_pkg::STAT_OK;
        result.path_length  = '0;
        result.query_length = '0;

        if (line_end)
        begin
            // Verdict, then rearm for the next line
            result.byte_kind = hgrl_pkg::KIND_VERDICT;
            priority if (method_failed_reg || phase_reg == PH_PREFIX)
                result.status = hgrl_pkg::STAT_BAD_METHOD;
            else if (path_count_reg == '0 || path_count_reg >= PATH_CAP)
                result.status = hgrl_pkg::STAT_BAD_PATH;
            else if ((phase_reg == PH_QUERY || phase_reg == PH_DONE_Q) &&
                     query_count_reg >= QUERY_CAP)
                result.status = hgrl_pkg::STAT_BAD_QUERY;
            else
            begin
                result.status       = hgrl_pkg::STAT_OK;
                result.path_length  = path_wide[hgrl_pkg::PLEN_W-1:0];
                result.query_length = query_wide[hgrl_pkg::QLEN_W-1:0];
            end
            phase_next         = PH_PREFIX;
            prefix_pos_next    = '0;
            method_failed_next = 1'b0;
            path_count_next    = '0;
            query_count_next   = '0;
        end
        else if (!method_failed_reg)
        begin
            unique case (phase_reg)
                PH_PREFIX:
                begin
                    if (char_byte == hgrl_pkg::prefix_char(prefix_pos_reg))
                    begin
                        prefix_pos_next = prefix_pos_reg + 2'd1;
                        if (prefix_pos_reg == 2'd3)
                            phase_next = PH_PATH;
                    end
                    else
                        method_failed_next = 1'b1;
                end
                PH_PATH:
                begin
                    priority if (hgrl_pkg::ends_target(char_byte))
                        phase_next = PH_DONE_NOQ;
                    else if (char_byte == hgrl_pkg::CHAR_QMARK)
                        phase_next = PH_QUERY;
                    else
                    begin
                        result.byte_kind = hgrl_pkg::KIND_PATH;
                        result.byte_out  = char_byte;
                        if (path_count_reg < PATH_CAP)
                            path_count_next = path_count_reg + PC_W'(1);
                    end
                end
                PH_QUERY:
                begin
                    if (hgrl_pkg::ends_target(char_byte))
                        phase_next = PH_DONE_Q;
                    else
                    begin
                        result.byte_kind = hgrl_pkg::KIND_QUERY;
                        result.byte_out  = char_byte;
                        if (query_count_reg < QUERY_CAP)
                            query_count_next = query_count_reg + QC_W'(1);
                    end
                end
                PH_DONE_Q:
                    phase_next = PH_DONE_Q;
                default:
                    // ended without '?', and any stray code
                    phase_next = PH_DONE_NOQ;
            endcase
        end
    end

    // State register, advanced only on an accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_PREFIX;
            prefix_pos_reg    <= '0;
            method_failed_reg <= 1'b0;
            path_count_reg    <= '0;
            query_count_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            prefix_pos_reg    <= prefix_pos_next;
            method_failed_reg <= method_failed_next;
            path_count_reg    <= path_count_next;
            query_count_reg   <= query_count_next;
        end
    end

endmodule

/* rtl/core/http_get_request_line_parser.sv */
// Top level of the HTTP GET request line parser: handshake and result register.
// Depends on hgrl_pkg, hgrl_in_if, hgrl_out_if and hgrl_parse.
//
//  channel  | dir | fields                                                   | role
//  ---------+-----+----------------------------------------------------------+------------------
//  chars    | in  | char_byte[7:0], line_end                                 | request line bytes
//  tokens   | out | byte_out[7:0], byte_kind[1:0], status[1:0],              | tagged bytes and
//           |     | path_length[5:0], query_length[6:0]                      | end verdict
//
// Every accepted item gives exactly one result item, in the next cycle, from the result
// register; one item per cycle sustained while tokens is not stalled.
// chars.ready is high while the result register is empty or being taken this cycle,
// so a stall on tokens holds chars in the same cycle, with no item lost.
// Reset (rst_n low, asynchronous) empties the result register and rearms the parser.
module http_get_request_line_parser
(
    input  logic       clk,
    input  logic       rst_n,
    hgrl_in_if.sink    chars,
    hgrl_out_if.source tokens
);

    logic                   accept;
    hgrl_pkg::hgrl_result_t result;
    hgrl_pkg::hgrl_result_t result_reg;
    logic                   valid_reg;

    assign chars.ready = !valid_reg || tokens.ready;
    assign accept      = chars.valid && chars.ready;

    hgrl_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .char_byte (chars.char_byte),
        .line_end  (chars.line_end),
        .result    (result)
    );

    // Result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (chars.ready)
            valid_reg <= chars.valid;
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result;
    end

    assign tokens.valid        = valid_reg;
    assign tokens.byte_out     = result_reg.byte_out;
    assign tokens.byte_kind    = result_reg.byte_kind;
    assign tokens.status       = result_reg.status;
    assign tokens.path_length  = result_reg.path_length;
    assign tokens.query_length = result_reg.query_length;

    // An accepted item always shows up as a result in the next cycle
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> tokens.valid)
        else $error("accepted item produced no result");

    // Only verdicts carry a status or lengths
    a_plain_items_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (tokens.valid && tokens.byte_kind != hgrl_pkg::KIND_VERDICT) |->
        (tokens.status == hgrl_pkg::STAT_OK && tokens.path_length == '0 &&
         tokens.query_length == '0))
        else $error("non-verdict item carries verdict fields");

    // An ok verdict never reports an empty path
    a_ok_has_path: assert property (@(posedge clk) disable iff (!rst_n)
        (tokens.valid && tokens.byte_kind == hgrl_pkg::KIND_VERDICT &&
         tokens.status == hgrl_pkg::STAT_OK) |-> tokens.path_length != '0)
        else $error("ok verdict with empty path");

    // Echoed path and query bytes are never terminators
    a_echo_not_terminator: assert property (@(posedge clk) disable iff (!rst_n)
        (tokens.valid && (tokens.byte_kind == hgrl_pkg::KIND_PATH ||
                          tokens.byte_kind == hgrl_pkg::KIND_QUERY)) |->
        !hgrl_pkg::ends_target(tokens.byte_out))
        else $error("terminator echoed as target byte");

endmodule
